FILE: sv/sidd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidd_pkg
// Shared types and constants of the sorted insert / descending drain unit.
// ----------------------------------------------------------------------------
package sidd_pkg;

  localparam int CAPACITY = 32;
  localparam int VALUE_W  = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;
  } out_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic ins;    // insert the broadcast value
    logic shift;  // move every entry one cell toward the head
  } cell_ctl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      valid;
    logic                      take;
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage
`default_nettype wire

FILE: sv/sidd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidd_cell
// One slot of the sorting chain. Slots hold values in descending order from
// the head; an insert pushes the smaller tail one slot down.
// ----------------------------------------------------------------------------
module sidd_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sidd_pkg::cell_ctl_t                  ctl,
  input  logic signed [sidd_pkg::VALUE_W-1:0]  ins_value,
  input  sidd_pkg::cell_link_t                 prev,
  input  sidd_pkg::cell_link_t                 next,
  output sidd_pkg::cell_link_t                 self
);
  import sidd_pkg::*;

  logic signed [VALUE_W-1:0] value;
  logic                      valid;
  logic                      take;

  // The new value belongs at or above this slot when the slot is empty or
  // holds a smaller value. Equal values stay ahead of the new one.
  assign take = !valid || (ins_value > value);

  assign self.value = value;
  assign self.valid = valid;
  assign self.take  = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= next.valid;
    end else if (ctl.ins && take) begin
      valid <= prev.take ? prev.valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= next.value;
    end else if (ctl.ins && take) begin
      value <= prev.take ? prev.value : ins_value;
    end
  end

endmodule
`default_nettype wire

FILE: sv/sorted_insert_descending_drain_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_descending_drain_unit
// Insertion sorter built as a chain of cells; drains a batch largest first.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready  | in_data  (value, last)
//   out     | output    | out_valid / out_ready| out_data (sorted_value,
//           |           |                      |           last_out, overflow)
//
// An input item is inserted in the cycle of its transfer, one item per cycle
// while filling; a full chain drops it and flags overflow. After a last item
// the input stalls while the chain shifts out one result per cycle through
// the output register; output stalls hold the chain in place. Reset clears
// the cell valid bits, overflow flag and sequencer; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_insert_descending_drain_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sidd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sidd_pkg::out_t out_data
);
  import sidd_pkg::*;

  state_t     state;
  logic       dropped;
  cell_ctl_t  ctl;
  cell_link_t self_lnk [CAPACITY];
  cell_link_t prev_lnk [CAPACITY];
  cell_link_t next_lnk [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic       in_xfer;
  logic       full;
  logic       load;
  logic       final_load;

  assign in_ready   = (state == ST_FILL);
  assign in_xfer    = in_valid && in_ready;
  assign full       = cell_valid[CAPACITY-1];
  assign load       = (state == ST_DRAIN) && (!out_valid || out_ready);
  assign final_load = load && !cell_valid[1];

  assign ctl.ins   = in_xfer && !full;
  assign ctl.shift = load;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign cell_valid[g] = self_lnk[g].valid;

    if (g == 0) begin : g_head
      assign prev_lnk[g] = '0;
    end else begin : g_prev
      assign prev_lnk[g] = self_lnk[g-1];
    end

    if (g == CAPACITY-1) begin : g_tail
      assign next_lnk[g] = '0;
    end else begin : g_next
      assign next_lnk[g] = self_lnk[g+1];
    end

    sidd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .ins_value (in_data.value),
      .prev      (prev_lnk[g]),
      .next      (next_lnk[g]),
      .self      (self_lnk[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_FILL: begin
          if (in_xfer && full) begin
            dropped <= 1'b1;
          end
          if (in_xfer && in_data.last) begin
            state <= ST_DRAIN;
          end
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_DRAIN: begin
          if (load) begin
            out_valid <= 1'b1;
            if (final_load) begin
              state   <= ST_FILL;
              dropped <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.sorted_value <= self_lnk[0].value;
      out_data.last_out     <= !cell_valid[1];
      out_data.overflow     <= dropped;
    end
  end

`ifndef NO_ASSERTIONS
  // Occupied cells always form one run starting at the head.
  a_valid_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid & (cell_valid + CAPACITY'(1))) == '0))
    else $error("cell valid bits are not contiguous from the head");

  // A drain never runs on an empty chain.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> cell_valid[0])
    else $error("drain with empty chain");

  // The final result of a drain leaves the chain empty and reopens the input.
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    final_load |=> (state == ST_FILL) && (cell_valid == '0) && out_data.last_out)
    else $error("drain did not end cleanly");

  // Head and second cell stay in descending order.
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    cell_valid[1] |-> (self_lnk[0].value >= self_lnk[1].value))
    else $error("chain head out of order");
`endif

endmodule
`default_nettype wire
